### design/s2pkvb_pkg.sv
// Package for the serial to parallel keyboard and video bridge.
// Holds the transfer payload types, the handshake phase type, register indexes and code mapping.
// Depends on nothing; every design file imports it.
package s2pkvb_pkg;

    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAIT    = 2'd1;

    localparam logic [7:0] TIMEOUT_RESET = 8'd23;

    localparam logic [9:0] CODE_ESC_IN   = 10'd203;
    localparam logic [9:0] CODE_ESC_OUT  = 10'd27;
    localparam logic [9:0] CTRL_LOW      = 10'd576;
    localparam logic [9:0] CTRL_HIGH     = 10'd603;
    localparam logic [9:0] LOWER_LOW     = 10'd96;
    localparam logic [9:0] LOWER_HIGH    = 10'd123;
    localparam logic [9:0] CASE_OFFSET   = 10'd32;
    localparam logic [9:0] MAPPED_LIMIT  = 10'd96;
    localparam logic [7:0] KBD_BIT7      = 8'd128;
    localparam logic [7:0] VIDEO_MASK    = 8'd127;

    localparam logic [6:0] CHAR_LF = 7'd10;
    localparam logic [6:0] CHAR_CR = 7'd13;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_WAIT_HIGH = 2'd1,
        PH_WAIT_LOW  = 2'd2,
        PH_PULSE     = 2'd3
    } kbd_phase_t;

    typedef struct packed {
        logic       rx_valid;
        logic [9:0] rx_code;
        logic       key_ready;
        logic       video_avail;
        logic [7:0] video_byte;
        logic       reset_switch;
    } in_item_t;

    typedef struct packed {
        logic [7:0] kbd_data;
        logic       key_strobe;
        logic       video_ack;
        logic       tx_valid;
        logic [6:0] tx_char;
        logic       rx_dropped;
        logic       cpu_reset;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [7:0] kbd_data;
        logic       key_strobe;
        logic       rx_dropped;
    } kbd_status_t;

    function automatic logic [9:0] map_code(input logic [9:0] code);
        logic [9:0] c;
        c = code;
        if (c == CODE_ESC_IN)
            c = CODE_ESC_OUT;
        if (c > CTRL_LOW && c < CTRL_HIGH)
            c = c - CTRL_LOW;
        if (c > LOWER_LOW && c < LOWER_HIGH)
            c = c - CASE_OFFSET;
        return c;
    endfunction

endpackage

### design/s2pkvb_kbd.sv
// Keyboard side: code mapping and the strobe and ready handshake sequencer.
// Depends on s2pkvb_pkg for the phase type and the code mapping function.
module s2pkvb_kbd (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic                  rx_valid,
    input  logic [9:0]            rx_code,
    input  logic                  key_ready,
    input  logic [7:0]            timeout,
    input  logic                  wait_mode,
    output s2pkvb_pkg::kbd_status_t status
);
    import s2pkvb_pkg::*;

    kbd_phase_t phase_reg, phase_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] hold_reg, hold_next;
    logic       strobe_reg, strobe_next;
    logic [9:0] mapped;
    logic       busy;

    always_comb
    begin
        mapped      = map_code(rx_code);
        busy        = (phase_reg != PH_IDLE);
        phase_next  = phase_reg;
        count_next  = count_reg;
        hold_next   = hold_reg;
        strobe_next = strobe_reg;

        if (rx_valid && !busy)
        begin
            if (mapped < MAPPED_LIMIT)
            begin
                hold_next   = mapped[7:0] | KBD_BIT7;
                strobe_next = 1'b1;
                count_next  = timeout;
                phase_next  = wait_mode ? PH_WAIT_HIGH : PH_PULSE;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                end
                PH_WAIT_HIGH:
                begin
                    if (key_ready || count_reg == 8'd0)
                    begin
                        strobe_next = 1'b0;
                        phase_next  = PH_WAIT_LOW;
                        count_next  = timeout;
                    end
                    else
                    begin
                        count_next = count_reg - 8'd1;
                    end
                end
                PH_WAIT_LOW:
                begin
                    if (!key_ready || count_reg == 8'd0)
                        phase_next = PH_IDLE;
                    else
                        count_next = count_reg - 8'd1;
                end
                PH_PULSE:
                begin
                    strobe_next = 1'b0;
                    phase_next  = PH_IDLE;
                end
            endcase
        end

        status.kbd_data   = hold_next;
        status.key_strobe = strobe_next;
        status.rx_dropped = rx_valid && busy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            count_reg  <= 8'd0;
            hold_reg   <= 8'd0;
            strobe_reg <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            hold_reg   <= hold_next;
            strobe_reg <= strobe_next;
        end
    end

endmodule

### design/s2pkvb_out.sv
// Result register: holds one result transfer and sends a second one for a carriage return.
// Depends on s2pkvb_pkg for the result payload type and character codes.
module s2pkvb_out (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  s2pkvb_pkg::out_item_t first,
    input  logic                  two,
    output logic                  load_ok,
    output logic                  out_valid,
    input  logic                  out_ready,
    output s2pkvb_pkg::out_item_t out_item
);
    import s2pkvb_pkg::*;

    logic      valid_reg, valid_next;
    logic      second_reg, second_next;
    out_item_t item_reg, item_next;

    always_comb
    begin
        load_ok     = !valid_reg || (out_ready && !second_reg);
        valid_next  = valid_reg;
        second_next = second_reg;
        item_next   = item_reg;
        if (load)
        begin
            valid_next  = 1'b1;
            second_next = two;
            item_next   = first;
        end
        else if (valid_reg && out_ready)
        begin
            if (second_reg)
            begin
                second_next       = 1'b0;
                item_next.tx_char = CHAR_CR;
                item_next.last    = 1'b1;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

### design/serial_to_parallel_keyboard_video_bridge.sv
// Top level of the serial to parallel keyboard and video bridge.
// Depends on s2pkvb_pkg, s2pkvb_kbd and s2pkvb_out.
//
// Each input transfer is one tick of sampled pins and an optional received code. It is held in
// an input register, worked on by the keyboard sequencer and the video path, and its result is
// loaded into a result register once that register can take it. One input transfer can be
// taken every cycle while the result register is free to load; a tick that takes a carriage
// return yields two result transfers (line feed, then carriage return), which both pass through
// the result register. Configuration writes are accepted in every cycle.
module serial_to_parallel_keyboard_video_bridge (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  s2pkvb_pkg::in_item_t                  in_item,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output s2pkvb_pkg::out_item_t                 out_item,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [s2pkvb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [7:0]                            cfg_data
);
    import s2pkvb_pkg::*;

    logic        in_valid_reg;
    in_item_t    in_reg;
    logic [7:0]  timeout_reg;
    logic        wait_reg;
    logic        load_ok;
    logic        fire;
    kbd_status_t kstat;
    out_item_t   first;
    logic        two;
    logic [6:0]  ch;

    assign fire      = in_valid_reg && load_ok;
    assign in_ready  = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_reg <= in_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            wait_reg    <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT: timeout_reg <= cfg_data;
                CFG_WAIT:    wait_reg    <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    s2pkvb_kbd u_kbd (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .rx_valid  (in_reg.rx_valid),
        .rx_code   (in_reg.rx_code),
        .key_ready (in_reg.key_ready),
        .timeout   (timeout_reg),
        .wait_mode (wait_reg),
        .status    (kstat)
    );

    always_comb
    begin
        ch  = in_reg.video_avail ? in_reg.video_byte[6:0] : 7'd0;
        two = in_reg.video_avail && (ch == CHAR_CR);
        first.kbd_data   = kstat.kbd_data;
        first.key_strobe = kstat.key_strobe;
        first.video_ack  = !in_reg.video_avail;
        first.tx_valid   = in_reg.video_avail;
        first.tx_char    = two ? CHAR_LF : ch;
        first.rx_dropped = kstat.rx_dropped;
        first.cpu_reset  = !in_reg.reset_switch;
        first.last       = !two;
    end

    s2pkvb_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .first     (first),
        .two       (two),
        .load_ok   (load_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
